// ----- sv/uart_tx_queue_crlf_macros.svh -----
// Assertion macros for the UART transmit queue block.
// Included by the top level; no other dependencies.
`ifndef UART_TX_QUEUE_CRLF_MACROS_SVH
`define UART_TX_QUEUE_CRLF_MACROS_SVH

`ifndef ASSERT_OFF
// Clocked check, switched off while reset is held
`define UTQC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check, active in every cycle
`define UTQC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define UTQC_ASSERT(lbl, clk, rst_n, prop, msg)
`define UTQC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ----- sv/utqc_pkg.sv -----
// Shared types and constants for the UART transmit queue block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package utqc_pkg;

  // Queue geometry
  localparam int QUEUE_DEPTH = 4096;
  localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
  localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int LEVEL_W     = 13;

  // Stream widths
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 32;

  // Characters
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;

  // Item kinds
  localparam logic ACT_PUT   = 1'b0;
  localparam logic ACT_READY = 1'b1;

  // Mode register codes
  localparam logic MODE_DIRECT = 1'b0;
  localparam logic MODE_QUEUED = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LF,
    ST_EMIT
  } utqc_state_t;

  // Advance a ring index with wrap at the queue depth
  function automatic logic [ADDR_W-1:0] next_idx(input logic [ADDR_W-1:0] i);
    next_idx = (i == ADDR_W'(QUEUE_DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

endpackage

`default_nettype wire

// ----- sv/uart_tx_queue_crlf.sv -----
// Top level of the UART transmit front end: ring queue with CR insertion.
// Depends on utqc_pkg and uart_tx_queue_crlf_macros.svh.
//
//   channel  direction  ports                        word
//   in       slave      in_tvalid/tready/tdata/tuser put or transmitter-ready
//   out      master     out_tvalid/tready/tdata/tuser one result per input word
//   cfg      write      cfg_we/cfg_wdata             queue_mode
//
// An item passes through accept, then result load; a queued line feed
// adds ST_LF, since its CR and LF are two writes through one write port.
// Pops read the memory at accept; the registered read data feeds the result.
// Reset: rst_n synchronous, clears indices, fill count, mode and handshake
// state; queue memory is not cleared. A stalled output holds the result in
// its register; the block then finishes the next item and waits to load it.
`timescale 1ns / 1ps
`default_nettype none
`include "uart_tx_queue_crlf_macros.svh"

module uart_tx_queue_crlf
  import utqc_pkg::*;
(
  input  wire                          clk,
  input  wire                          rst_n,
  // configuration
  input  wire                          cfg_we,
  input  wire                          cfg_wdata,
  // input stream
  input  wire                          in_tvalid,
  output logic                         in_tready,
  input  wire  [IN_TDATA_W-1:0]        in_tdata,   // [7:0] data_byte
  input  wire  [0:0]                   in_tuser,   // [0] action
  // result stream
  output logic                         out_tvalid,
  input  wire                          out_tready,
  output logic [OUT_TDATA_W-1:0]       out_tdata,  // [7:0] out_byte, [9:8] dropped,
                                                   // [10] tx_ien, [11] rx_ien,
                                                   // [24:12] level, rest zero
  output logic [0:0]                   out_tuser   // [0] out_valid
);

  // Control state
  utqc_state_t         state_r, state_nxt;
  logic                mode_r;
  logic [ADDR_W-1:0]   rd_idx_r, rd_idx_nxt;
  logic [ADDR_W-1:0]   wr_idx_r, wr_idx_nxt;
  logic [FILL_W-1:0]   fill_r, fill_nxt;

  // Item registers
  logic [7:0]          data_r, data_nxt;
  logic                direct_r, direct_nxt;
  logic                pop_r, pop_nxt;
  logic [1:0]          drop_r, drop_nxt;

  // Memory port
  logic [7:0]          queue_mem [QUEUE_DEPTH];
  logic                mem_we, mem_re;
  logic [ADDR_W-1:0]   mem_wa;
  logic [7:0]          mem_wd;
  logic [7:0]          rd_data_r;

  // Output register
  logic                out_tvalid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;
  logic                out_tuser_r;

  logic                accept;
  logic                out_ld;
  logic                push_ok;
  logic                is_put;
  logic [7:0]          res_byte;
  logic                res_valid;
  logic [LEVEL_W-1:0]  res_level;

  assign accept  = in_tvalid & in_tready;
  assign push_ok = fill_r < FILL_W'(QUEUE_DEPTH);
  assign is_put  = (in_tuser[0] == ACT_PUT);

  // Handshake outputs
  always_comb begin
    in_tready = (state_r == ST_IDLE);
    out_ld    = (state_r == ST_EMIT) && (!out_tvalid_r || out_tready);
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (is_put && mode_r == MODE_QUEUED && in_tdata[7:0] == CH_LF) begin
            state_nxt = ST_LF;
          end else begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_LF:   state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (out_ld) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Queue datapath: push, pop, drop count
  always_comb begin
    rd_idx_nxt = rd_idx_r;
    wr_idx_nxt = wr_idx_r;
    fill_nxt   = fill_r;
    data_nxt   = data_r;
    direct_nxt = direct_r;
    pop_nxt    = pop_r;
    drop_nxt   = drop_r;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_wa     = wr_idx_r;
    mem_wd     = in_tdata[7:0];

    if (accept) begin
      data_nxt   = in_tdata[7:0];
      direct_nxt = is_put && (mode_r == MODE_DIRECT);
      pop_nxt    = 1'b0;
      drop_nxt   = 2'd0;
      if (is_put) begin
        if (mode_r == MODE_QUEUED) begin
          // first push: CR ahead of a line feed, else the byte itself
          mem_wd = (in_tdata[7:0] == CH_LF) ? CH_CR : in_tdata[7:0];
          if (push_ok) begin
            mem_we     = 1'b1;
            wr_idx_nxt = next_idx(wr_idx_r);
            fill_nxt   = fill_r + 1'b1;
          end else begin
            drop_nxt = 2'd1;
          end
        end
      end else if (fill_r != '0) begin
        // pop the oldest byte
        mem_re     = 1'b1;
        rd_idx_nxt = next_idx(rd_idx_r);
        fill_nxt   = fill_r - 1'b1;
        pop_nxt    = 1'b1;
      end
    end else if (state_r == ST_LF) begin
      // second push: the line feed
      mem_wd = CH_LF;
      if (push_ok) begin
        mem_we     = 1'b1;
        wr_idx_nxt = next_idx(wr_idx_r);
        fill_nxt   = fill_r + 1'b1;
      end else begin
        drop_nxt = drop_r + 2'd1;
      end
    end
  end

  // Result word
  always_comb begin
    res_valid = direct_r | pop_r;
    res_byte  = direct_r ? data_r : (pop_r ? rd_data_r : 8'd0);
    res_level = LEVEL_W'(fill_r);
  end

  // Queue memory: one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      queue_mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_r <= queue_mem[rd_idx_r];
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      mode_r       <= MODE_DIRECT;
      rd_idx_r     <= '0;
      wr_idx_r     <= '0;
      fill_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_idx_r <= rd_idx_nxt;
      wr_idx_r <= wr_idx_nxt;
      fill_r   <= fill_nxt;
      if (cfg_we) begin
        mode_r <= cfg_wdata;
      end
      if (out_ld) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // Item and result payload registers
  always_ff @(posedge clk) begin
    data_r   <= data_nxt;
    direct_r <= direct_nxt;
    pop_r    <= pop_nxt;
    drop_r   <= drop_nxt;
    if (out_ld) begin
      out_tuser_r <= res_valid;
      out_tdata_r <= {(OUT_TDATA_W - LEVEL_W - 12)'(0), res_level,
                      (fill_r < FILL_W'(QUEUE_DEPTH)), (fill_r != '0),
                      drop_r, res_byte};
    end
  end

  assign out_tvalid   = out_tvalid_r;
  assign out_tdata    = out_tdata_r;
  assign out_tuser[0] = out_tuser_r;

  // Checks
  `UTQC_ASSERT(a_fill_bound, clk, rst_n, fill_r <= FILL_W'(QUEUE_DEPTH), "fill count beyond depth")
  `UTQC_ASSERT(a_fill_step, clk, rst_n, $past(rst_n) |-> (fill_r == $past(fill_r) || fill_r == $past(fill_r) + 1'b1 || fill_r == $past(fill_r) - 1'b1), "fill count jumped")
  `UTQC_ASSERT(a_recv_full, clk, rst_n, out_tvalid |-> (out_tdata[11] == (out_tdata[24:12] != LEVEL_W'(QUEUE_DEPTH))), "rx_ien disagrees with level")
  `UTQC_ASSERT(a_lf_is_put, clk, rst_n, (state_r == ST_LF) |-> (!direct_r && !pop_r), "line feed state on a non-queued item")

endmodule

`default_nettype wire

// ----- tb/utqc_tx_check.sv -----
// Result checker for the UART transmit queue: watches all three channels,
// predicts each result word from a private copy of the queue, compares in order.
// Depends on utqc_pkg for widths, characters and codes.
`timescale 1ns / 1ps

module utqc_tx_check
  import utqc_pkg::*;
(
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    cfg_we,
  input  wire                    cfg_wdata,
  input  wire                    in_tvalid,
  input  wire                    in_tready,
  input  wire [IN_TDATA_W-1:0]   in_tdata,   // [7:0] data_byte
  input  wire [0:0]              in_tuser,   // [0] action
  input  wire                    out_tvalid,
  input  wire                    out_tready,
  input  wire [OUT_TDATA_W-1:0]  out_tdata,  // [7:0] out_byte, [9:8] dropped,
                                             // [10] tx_ien, [11] rx_ien, [24:12] level
  input  wire [0:0]              out_tuser,  // [0] out_valid
  output int                     fail_count,
  output int                     awaiting,
  output int                     fill_now,
  output int                     results_seen,
  output int                     bytes_popped,
  output int                     bytes_dropped,
  output int                     peak_fill
);

  typedef struct packed {
    logic               sent;
    logic [7:0]         tx_byte;
    logic [1:0]         dropped;
    logic               tx_ien;
    logic               rx_ien;
    logic [LEVEL_W-1:0] level;
  } tx_result_t;

  tx_result_t       pending_results[$];
  logic [7:0]       queue_mem [QUEUE_DEPTH];
  logic [ADDR_W-1:0] rd_ptr, wr_ptr;
  logic [FILL_W-1:0] fill;
  logic             mode;
  int               errors, results, pops, drops, peak;

  initial begin
    errors = 0;
    results = 0;
    pops = 0;
    drops = 0;
    peak = 0;
  end

  task automatic report_mismatch(input string what);
    errors++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // Store one byte unless the queue is full; return 1 when it is lost
  function automatic logic [1:0] push_byte(input logic [7:0] b);
    if (fill == QUEUE_DEPTH) return 2'd1;
    queue_mem[wr_ptr] = b;
    // depth is a power of two, so the pointer wraps by itself
    wr_ptr = wr_ptr + 1'b1;
    fill = fill + 1'b1;
    return 2'd0;
  endfunction

  // Work out the result word for one accepted input word
  task automatic predict_result(input logic act, input logic [7:0] b,
                                output tx_result_t r);
    r = '0;
    if (act == ACT_PUT) begin
      if (mode == MODE_DIRECT) begin
        r.sent = 1'b1;
        r.tx_byte = b;
      end else begin
        // a line feed goes out as CR then LF
        if (b == CH_LF) r.dropped = r.dropped + push_byte(CH_CR);
        r.dropped = r.dropped + push_byte(b);
      end
    end else if (fill != 0) begin
      // ready pops in either mode
      r.sent = 1'b1;
      r.tx_byte = queue_mem[rd_ptr];
      rd_ptr = rd_ptr + 1'b1;
      fill = fill - 1'b1;
      pops++;
    end
    drops += r.dropped;
    r.tx_ien = (fill != 0);
    r.rx_ien = (fill < QUEUE_DEPTH);
    r.level = LEVEL_W'(fill);
    if (fill > peak) peak = fill;
  endtask

  task automatic cmp_field(input string name, input logic [15:0] got,
                           input logic [15:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d: %s is 0x%0h, expected 0x%0h",
                                results, name, got, want));
    end
  endtask

  // Compare the accepted result word with the oldest prediction
  task automatic check_result();
    tx_result_t want;
    results++;
    if (pending_results.size() == 0) begin
      report_mismatch($sformatf("result %0d arrived with nothing outstanding", results));
      return;
    end
    want = pending_results.pop_front();
    cmp_field("out_valid", out_tuser[0], want.sent);
    cmp_field("out_byte", out_tdata[7:0], want.tx_byte);
    cmp_field("dropped", out_tdata[9:8], want.dropped);
    cmp_field("tx_ien", out_tdata[10], want.tx_ien);
    cmp_field("rx_ien", out_tdata[11], want.rx_ien);
    cmp_field("level", out_tdata[24:12], want.level);
    cmp_field("padding", out_tdata[31:25], '0);
  endtask

  always @(posedge clk) begin
    tx_result_t want;
    if (!rst_n) begin
      rd_ptr = '0;
      wr_ptr = '0;
      fill = '0;
      mode = MODE_DIRECT;
      pending_results.delete();
    end else begin
      if (out_tvalid && out_tready) check_result();
      if (cfg_we) mode = cfg_wdata;
      if (in_tvalid && in_tready) begin
        predict_result(in_tuser[0], in_tdata, want);
        pending_results.push_back(want);
      end
    end
    // publish after the update so the stimulus reads settled values
    awaiting      <= pending_results.size();
    fill_now      <= fill;
    fail_count    <= errors;
    results_seen  <= results;
    bytes_popped  <= pops;
    bytes_dropped <= drops;
    peak_fill     <= peak;
  end

endmodule

// ----- tb/testbench.sv -----
// Top of the UART transmit queue testbench: clock, reset, stimulus, receiver
// back-pressure, watchdog and verdict. Depends on utqc_pkg, utqc_tx_check and
// the uart_tx_queue_crlf block.
`timescale 1ns / 1ps

module testbench;
  import utqc_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int LONG_HOLD   = 400;
  localparam int PHASE_WORDS = 210;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_we = 1'b0;
  logic                   cfg_wdata = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;   // [7:0] data_byte
  logic [0:0]             in_tuser = '0;   // [0] action
  logic                   out_tready = 1'b0;
  wire                    in_tready;
  wire                    out_tvalid;
  wire [OUT_TDATA_W-1:0]  out_tdata;       // [7:0] out_byte, [9:8] dropped,
                                           // [10] tx_ien, [11] rx_ien, [24:12] level
  wire [0:0]              out_tuser;       // [0] out_valid

  int fail_count, awaiting, fill_now, results_seen, bytes_popped, bytes_dropped, peak_fill;
  int rx_stall_pct = 0;
  int stall_req = 0;
  int tx_idle_pct = 0;
  int words_sent = 0;
  int mode_writes = 0;
  int quiet_cycles = 0;

  uart_tx_queue_crlf DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  utqc_tx_check tx_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .fail_count    (fail_count),
    .awaiting      (awaiting),
    .fill_now      (fill_now),
    .results_seen  (results_seen),
    .bytes_popped  (bytes_popped),
    .bytes_dropped (bytes_dropped),
    .peak_fill     (peak_fill)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Receiver: random stalls, plus a long hold-off whenever one is requested
  initial begin : receiver
    int hold_left;
    int holds_served;
    hold_left = 0;
    holds_served = 0;
    forever begin
      @(posedge clk);
      if (hold_left == 0 && stall_req != holds_served) begin
        hold_left = LONG_HOLD;
        holds_served++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // Watchdog: end the run when no word moves on either channel for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
               QUIET_LIMIT, awaiting);
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Byte mix weighted towards line feeds, CR and the extremes
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(11))
      0, 1:    return CH_LF;
      2:       return CH_CR;
      3:       return 8'h00;
      4:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Offer one word, idling beforehand at the current rate; return once taken
  task automatic send_word(input logic act, input logic [7:0] b);
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    words_sent++;
  endtask

  task automatic send_random(input int ready_pct);
    if ($urandom_range(99) < ready_pct) send_word(ACT_READY, pick_byte());
    else send_word(ACT_PUT, pick_byte());
  endtask

  // Hold the sender until every predicted result has come back
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (awaiting != 0);
  endtask

  task automatic write_mode(input logic m);
    wait_drained();
    repeat (2) @(posedge clk);
    cfg_wdata <= m;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
    mode_writes++;
  endtask

  initial begin : stimulus
    int tx_idle_by_phase [4];
    int rx_stall_by_phase [4];
    tx_idle_by_phase  = '{0, 57, 0, 18};
    rx_stall_by_phase = '{0, 0, 57, 18};

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Direct mode after reset: extremes, unexpanded LF, ready on empty
    send_word(ACT_PUT, 8'h00);
    send_word(ACT_PUT, 8'hFF);
    send_word(ACT_PUT, CH_LF);
    send_word(ACT_READY, 8'hFF);

    // Queued mode: LF expansion, CR on its own, and pops
    write_mode(MODE_QUEUED);
    send_word(ACT_PUT, CH_LF);
    send_word(ACT_PUT, CH_CR);
    send_word(ACT_PUT, 8'hA5);
    send_word(ACT_PUT, 8'h5A);
    send_word(ACT_READY, 8'h00);
    send_word(ACT_READY, 8'h00);
    send_word(ACT_READY, 8'h00);

    // Back to direct with bytes still queued: contents kept, readies still drain
    write_mode(MODE_DIRECT);
    send_word(ACT_READY, 8'h00);
    send_word(ACT_PUT, CH_LF);
    send_word(ACT_READY, 8'h00);
    send_word(ACT_READY, 8'h00);

    write_mode(MODE_QUEUED);
    send_word(ACT_READY, 8'h00);
    send_word(ACT_PUT, 8'h80);
    send_word(ACT_PUT, 8'h7F);

    // Random traffic over the four idling phases, both modes in each
    for (int ph = 0; ph < 4; ph++) begin
      tx_idle_pct = tx_idle_by_phase[ph];
      rx_stall_pct <= rx_stall_by_phase[ph];
      for (int half = 0; half < 2; half++) begin
        write_mode(((ph + half) % 2 == 0) ? MODE_QUEUED : MODE_DIRECT);
        for (int n = 0; n < PHASE_WORDS; n++) begin
          // long receiver hold-off while the sender keeps offering
          if (ph == 0 && half == 0 && n == 60) stall_req <= stall_req + 1;
          send_random(45);
        end
      end
    end

    tx_idle_pct = 0;
    rx_stall_pct <= 0;
    wait_drained();
    repeat (10) @(posedge clk);
    $display("Sent %0d words and checked %0d results across %0d mode writes.",
             words_sent, results_seen, mode_writes);
    $display("Queue peaked at %0d bytes; %0d bytes popped, %0d dropped when full.",
             peak_fill, bytes_popped, bytes_dropped);
    if (fail_count == 0 && awaiting == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
